>>> rtl/pcr_pkg.sv
// ----------------------------------------------------------------------------
// pcr_pkg
// Shared widths, register indexes and types of the particle cell remap block.
// ----------------------------------------------------------------------------
`default_nettype none

package pcr_pkg;

  localparam int CELL_BITS = 16;
  localparam int FRAC_BITS = 16;

  localparam int DIM_W   = 2;
  localparam int GHOST_W = 4;
  localparam int RATIO_W = 8 + FRAC_BITS;
  localparam int OFS_W   = CELL_BITS + FRAC_BITS;

  // signed source coordinate, cell minus ghosts with the fraction below it
  localparam int S_W    = CELL_BITS + 1 + FRAC_BITS;
  localparam int PROD_W = S_W + RATIO_W + 1;
  localparam int SCL_W  = PROD_W - FRAC_BITS;
  localparam int T_W    = SCL_W + 1;

  // register file
  localparam int NUM_REGS = 8;
  localparam int IDX_W    = 3;
  localparam int DATA_W   = ((OFS_W > 32) || (RATIO_W > 32)) ? 64 : 32;
  localparam int STRIDE_W = (DATA_W == 64) ? 3 : 2;
  localparam int ADDR_W   = IDX_W + STRIDE_W;

  typedef enum logic [IDX_W-1:0] {
    REG_DIMENSIONS = 3'd0,
    REG_SRC_GHOSTS = 3'd1,
    REG_RATIO_X    = 3'd2,
    REG_RATIO_Y    = 3'd3,
    REG_RATIO_Z    = 3'd4,
    REG_OFFSET_X   = 3'd5,
    REG_OFFSET_Y   = 3'd6,
    REG_OFFSET_Z   = 3'd7
  } pcr_reg_e;

  // per-axis settings handed to one axis datapath
  typedef struct packed {
    logic               active;
    logic [GHOST_W-1:0] src_ghosts;
    logic [RATIO_W-1:0] ratio;
    logic [OFS_W-1:0]   offset;
  } pcr_axis_cfg_t;

endpackage

`default_nettype wire

>>> rtl/pcr_axis.sv
// ----------------------------------------------------------------------------
// pcr_axis
// One axis of the remap: multiply stage, then offset add, split and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module pcr_axis (
  input  wire logic                          clk_i,
  input  wire pcr_pkg::pcr_axis_cfg_t        cfg_i,
  input  wire logic [pcr_pkg::CELL_BITS-1:0] cell_i,
  input  wire logic [pcr_pkg::FRAC_BITS-1:0] frac_i,
  output logic      [pcr_pkg::CELL_BITS-1:0] new_cell_o,
  output logic      [pcr_pkg::FRAC_BITS-1:0] new_frac_o,
  output logic                               oor_o
);
  import pcr_pkg::*;

  logic signed [CELL_BITS:0]   cell_rel;
  logic signed [S_W-1:0]       s_val;
  logic signed [PROD_W-1:0]    prod_d, prod_q;
  logic [CELL_BITS-1:0]        cell_q;
  logic [FRAC_BITS-1:0]        frac_q;

  logic signed [SCL_W-1:0]     scl;
  logic signed [T_W-1:0]       t_val;
  logic                        t_neg, t_over;
  logic [CELL_BITS-1:0]        new_cell_d, new_cell_q;
  logic [FRAC_BITS-1:0]        new_frac_d, new_frac_q;
  logic                        oor_d, oor_q;

  // stage 1: s = (cell - ghosts) . frac, times ratio
  always_comb begin
    cell_rel = $signed({1'b0, cell_i}) -
               $signed({{(CELL_BITS + 1 - GHOST_W){1'b0}}, cfg_i.src_ghosts});
    s_val    = $signed({cell_rel, frac_i});
    prod_d   = PROD_W'(s_val) * PROD_W'($signed({1'b0, cfg_i.ratio}));
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    cell_q <= cell_i;
    frac_q <= frac_i;
  end

  // stage 2: floor to frac bits, add offset, split into cell and fraction and clamp; inactive axes pass through
  always_comb begin
    scl    = $signed(prod_q[PROD_W-1:FRAC_BITS]);
    t_val  = $signed({scl[SCL_W-1], scl}) +
             $signed({{(T_W - OFS_W){cfg_i.offset[OFS_W-1]}}, cfg_i.offset});
    t_neg  = t_val[T_W-1];
    t_over = !t_neg && (|t_val[T_W-2:FRAC_BITS+CELL_BITS]);
    if (!cfg_i.active) begin
      new_cell_d = cell_q;
      new_frac_d = frac_q;
      oor_d      = 1'b0;
    end else begin
      new_frac_d = t_val[FRAC_BITS-1:0];
      oor_d      = t_neg || t_over;
      if (t_neg) begin
        new_cell_d = '0;
      end else if (t_over) begin
        new_cell_d = '1;
      end else begin
        new_cell_d = t_val[FRAC_BITS+CELL_BITS-1:FRAC_BITS];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    new_cell_q <= new_cell_d;
    new_frac_q <= new_frac_d;
    oor_q      <= oor_d;
  end

  assign new_cell_o = new_cell_q;
  assign new_frac_o = new_frac_q;
  assign oor_o      = oor_q;

endmodule

`default_nettype wire

>>> rtl/particle_cell_remap_refined_grid.sv
// ----------------------------------------------------------------------------
// particle_cell_remap_refined_grid
// Maps a particle's source cell and fraction onto a refined destination grid.
// ----------------------------------------------------------------------------
// Usage:
//   A request (cell_x/y/z_i, frac_x/y/z_i) is taken at a rising edge with
//   start high and busy low. busy is always low, so a request may be given
//   in every cycle. Each request gives one result on new_cell_*_o,
//   new_frac_*_o and out_of_range_o, shown for exactly one cycle with
//   done_o high; results come out in request order.
//   done_o goes high once the request has passed the input register,
//   multiply register and result register. Throughput is one request
//   per cycle, set by the one multiplier per axis in the multiply stage.
//   The receiver cannot stall: a result is gone after its done_o cycle.
//   Registers are written over the APB port (4-byte stride); the user
//   writes them only while no request is in flight, which the block does
//   not enforce. Reads return the stored values.
//   Reset clears the request pipeline and loads dimensions 1, no source
//   ghosts, ratios 1.0 and offsets 0.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_cell_remap_refined_grid (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // request channel
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [pcr_pkg::CELL_BITS-1:0] cell_x_i,
  input  wire logic [pcr_pkg::CELL_BITS-1:0] cell_y_i,
  input  wire logic [pcr_pkg::CELL_BITS-1:0] cell_z_i,
  input  wire logic [pcr_pkg::FRAC_BITS-1:0] frac_x_i,
  input  wire logic [pcr_pkg::FRAC_BITS-1:0] frac_y_i,
  input  wire logic [pcr_pkg::FRAC_BITS-1:0] frac_z_i,
  // result channel
  output logic                               done_o,
  output logic      [pcr_pkg::CELL_BITS-1:0] new_cell_x_o,
  output logic      [pcr_pkg::CELL_BITS-1:0] new_cell_y_o,
  output logic      [pcr_pkg::CELL_BITS-1:0] new_cell_z_o,
  output logic      [pcr_pkg::FRAC_BITS-1:0] new_frac_x_o,
  output logic      [pcr_pkg::FRAC_BITS-1:0] new_frac_y_o,
  output logic      [pcr_pkg::FRAC_BITS-1:0] new_frac_z_o,
  output logic                               out_of_range_o,
  // configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pcr_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [pcr_pkg::DATA_W-1:0]    pwdata,
  output logic      [pcr_pkg::DATA_W-1:0]    prdata,
  output logic                               pready
);
  import pcr_pkg::*;

  // registers
  logic [DIM_W-1:0]   dimensions_q;
  logic [GHOST_W-1:0] src_ghosts_q;
  logic [RATIO_W-1:0] ratio_q  [3];
  logic [OFS_W-1:0]   offset_q [3];

  pcr_reg_e           reg_idx;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_idx = pcr_reg_e'(paddr[ADDR_W-1:STRIDE_W]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dimensions_q <= DIM_W'(1);
      src_ghosts_q <= '0;
      for (int i = 0; i < 3; i++) begin
        ratio_q[i]  <= RATIO_W'(1) << FRAC_BITS;
        offset_q[i] <= '0;
      end
    end else if (wr_en) begin
      case (reg_idx)
        REG_DIMENSIONS: dimensions_q <= pwdata[DIM_W-1:0];
        REG_SRC_GHOSTS: src_ghosts_q <= pwdata[GHOST_W-1:0];
        REG_RATIO_X:    ratio_q[0]   <= pwdata[RATIO_W-1:0];
        REG_RATIO_Y:    ratio_q[1]   <= pwdata[RATIO_W-1:0];
        REG_RATIO_Z:    ratio_q[2]   <= pwdata[RATIO_W-1:0];
        REG_OFFSET_X:   offset_q[0]  <= pwdata[OFS_W-1:0];
        REG_OFFSET_Y:   offset_q[1]  <= pwdata[OFS_W-1:0];
        REG_OFFSET_Z:   offset_q[2]  <= pwdata[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DIMENSIONS: prdata = DATA_W'(dimensions_q);
      REG_SRC_GHOSTS: prdata = DATA_W'(src_ghosts_q);
      REG_RATIO_X:    prdata = DATA_W'(ratio_q[0]);
      REG_RATIO_Y:    prdata = DATA_W'(ratio_q[1]);
      REG_RATIO_Z:    prdata = DATA_W'(ratio_q[2]);
      REG_OFFSET_X:   prdata = DATA_W'(offset_q[0]);
      REG_OFFSET_Y:   prdata = DATA_W'(offset_q[1]);
      REG_OFFSET_Z:   prdata = DATA_W'(offset_q[2]);
      default:        prdata = '0;
    endcase
  end

  // zero dimensions counts as one axis, so x is always active
  logic [2:0] active;
  assign active[0] = 1'b1;
  assign active[1] = (dimensions_q >= DIM_W'(2));
  assign active[2] = (dimensions_q == DIM_W'(3));

  pcr_axis_cfg_t axis_cfg [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      axis_cfg[i].active     = active[i];
      axis_cfg[i].src_ghosts = src_ghosts_q;
      axis_cfg[i].ratio      = ratio_q[i];
      axis_cfg[i].offset     = offset_q[i];
    end
  end

  // request pipeline
  logic                 accept;
  logic [2:0]           vld_q;
  logic [CELL_BITS-1:0] cell_q [3];
  logic [FRAC_BITS-1:0] frac_q [3];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cell_q[0] <= cell_x_i;
      cell_q[1] <= cell_y_i;
      cell_q[2] <= cell_z_i;
      frac_q[0] <= frac_x_i;
      frac_q[1] <= frac_y_i;
      frac_q[2] <= frac_z_i;
    end
  end

  logic [CELL_BITS-1:0] new_cell [3];
  logic [FRAC_BITS-1:0] new_frac [3];
  logic [2:0]           oor;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    pcr_axis u_axis (
      .clk_i      (clk_i),
      .cfg_i      (axis_cfg[a]),
      .cell_i     (cell_q[a]),
      .frac_i     (frac_q[a]),
      .new_cell_o (new_cell[a]),
      .new_frac_o (new_frac[a]),
      .oor_o      (oor[a])
    );
  end

  assign done_o         = vld_q[2];
  assign new_cell_x_o   = new_cell[0];
  assign new_cell_y_o   = new_cell[1];
  assign new_cell_z_o   = new_cell[2];
  assign new_frac_x_o   = new_frac[0];
  assign new_frac_y_o   = new_frac[1];
  assign new_frac_z_o   = new_frac[2];
  assign out_of_range_o = |oor;

  // every request leads to a result strobe on done_o
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##3 done_o)
    else $error("request did not produce a result after three cycles");

  // no result without a request
  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 3))
    else $error("result strobe without a matching request");

  // single-axis mode passes y through untouched
  a_pass_y : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (dimensions_q <= DIM_W'(1))) |->
      (new_cell_y_o == $past(cell_y_i, 3)) && (new_frac_y_o == $past(frac_y_i, 3)))
    else $error("passive y axis was modified");

  // out of range in single-axis mode means x was clamped to an edge
  a_clamp_x : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_of_range_o && (dimensions_q <= DIM_W'(1))) |->
      ((new_cell_x_o == '0) || (new_cell_x_o == '1)))
    else $error("flagged x cell is not clamped");

endmodule

`default_nettype wire
